// ===== sv/ckm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckm_pkg
// Shared types, codes and sizes of the connection keepalive monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ckm_pkg;

    // Table size and tick result cap
    localparam int CONNECTIONS = 32;
    localparam int MAX_RESULTS = 32;
    localparam int SLOT_W      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int CONN_W   = 5;
    localparam int TIME_W   = 32;
    localparam int SEQ_W    = 63;
    localparam int ACTION_W = 3;
    localparam int IVAL_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MSG_COUNT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MSG_PLAIN = 3'd4;

    // Result action codes
    localparam logic [ACTION_W-1:0] ACT_NONE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PING = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PASS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DUP  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 2'd2;

    // Configuration reset values
    localparam logic [IVAL_W-1:0] PING_INTERVAL_RST = 16'd30;
    localparam logic [IVAL_W-1:0] LOSS_INTERVAL_RST = 16'd60;
    localparam logic [SEQ_W-1:0]  START_SEQ_RST     = '0;

    // Classified command kinds
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ADD,
        CMD_DELETE,
        CMD_TICK,
        CMD_MSG
    } cmd_kind_t;

    // One classified command as it travels through the queue
    typedef struct packed {
        cmd_kind_t          kind;
        logic               counted;
        logic [CONN_W-1:0]  conn;
        logic [TIME_W-1:0]  now;
        logic [SEQ_W-1:0]   seq;
    } cmd_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== sv/ckm_ram.sv =====
// ----------------------------------------------------------------------------
// ckm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/ckm_queue.sv =====
// ----------------------------------------------------------------------------
// ckm_queue
// Short command queue that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire ckm_pkg::cmd_t           push_cmd,
    input  wire logic                    pop,
    output ckm_pkg::cmd_t                head_cmd,
    output ckm_pkg::queue_status_t       status
);
    import ckm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ckm_front.sv =====
// ----------------------------------------------------------------------------
// ckm_front
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_front (
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [103:0]           s_axis_tdata,
    input  wire logic [2:0]             s_axis_tuser,
    input  wire ckm_pkg::queue_status_t queue_status,
    output logic                        push,
    output ckm_pkg::cmd_t               push_cmd
);
    import ckm_pkg::*;

    logic [FUNC_W-1:0] func;
    logic [CONN_W-1:0] conn;
    logic              conn_valid;

    assign func = s_axis_tuser[FUNC_W-1:0];
    assign conn = s_axis_tdata[CONN_W-1:0];
    assign conn_valid = (int'(conn) < CONNECTIONS);

    // Take a transaction whenever the queue has room
    assign s_axis_tready = !queue_status.full;
    assign push          = s_axis_tvalid && !queue_status.full;

    // Classify the function code; a tick ignores the slot
    always_comb
    begin
        push_cmd.conn    = conn;
        push_cmd.now     = s_axis_tdata[CONN_W +: TIME_W];
        push_cmd.seq     = s_axis_tdata[CONN_W + TIME_W +: SEQ_W];
        push_cmd.counted = (func == FUNC_MSG_COUNT);
        push_cmd.kind    = CMD_NOP;
        unique case (func)
            FUNC_TICK:      push_cmd.kind = CMD_TICK;
            FUNC_ADD:       push_cmd.kind = conn_valid ? CMD_ADD : CMD_NOP;
            FUNC_DELETE:    push_cmd.kind = conn_valid ? CMD_DELETE : CMD_NOP;
            FUNC_MSG_COUNT,
            FUNC_MSG_PLAIN: push_cmd.kind = conn_valid ? CMD_MSG : CMD_NOP;
            default:        push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ckm_back.sv =====
// ----------------------------------------------------------------------------
// ckm_back
// Executes queued commands against the connection table and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module ckm_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ckm_pkg::cmd_t                         head_cmd,
    input  wire ckm_pkg::queue_status_t                queue_status,
    output logic                                       pop,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [ckm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ckm_pkg::SEQ_W-1:0]             cfg_wdata,
    output logic                                       ram_we,
    output logic [ckm_pkg::SLOT_W-1:0]                 ram_waddr,
    output logic [ckm_pkg::TIME_W-1:0]                 ram_wdata,
    output logic [ckm_pkg::SLOT_W-1:0]                 ram_raddr,
    input  wire logic [ckm_pkg::TIME_W-1:0]            ram_rdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [7:0]                                 m_axis_tdata, // slot
    output logic [2:0]                                 m_axis_tuser, // action
    output logic                                       m_axis_tlast
);
    import ckm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t               state_reg,      state_next;
    logic [CONNECTIONS-1:0] tracked_reg,  tracked_next;
    logic [CONNECTIONS-1:0] pinged_reg,   pinged_next;
    logic [SEQ_W-1:0]     last_seq_reg,   last_seq_next;
    logic [IVAL_W-1:0]    ping_ival_reg,  ping_ival_next;
    logic [IVAL_W-1:0]    loss_ival_reg,  loss_ival_next;
    logic [SLOT_W-1:0]    idx_reg,        idx_next;
    logic [CNT_W-1:0]     cnt_reg,        cnt_next;
    logic [TIME_W-1:0]    now_reg,        now_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ACTION_W-1:0]  pend_action_reg, pend_action_next;
    logic [CONN_W-1:0]    pend_slot_reg,  pend_slot_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [ACTION_W-1:0]  out_action_reg, out_action_next;
    logic [CONN_W-1:0]    out_slot_reg,   out_slot_next;
    logic                 out_last_reg,   out_last_next;

    logic                 out_free;
    logic [SLOT_W-1:0]    head_idx;
    logic                 last_idx;
    logic [TIME_W-1:0]    elapsed;
    logic                 hit_drop;
    logic                 hit_ping;
    logic                 hit;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign head_idx  = SLOT_W'(head_cmd.conn);
    assign last_idx  = (idx_reg == SLOT_W'(CONNECTIONS - 1));
    assign ram_raddr = idx_reg;

    // Scan compare on the slot just read
    assign elapsed  = now_reg - ram_rdata;
    assign hit_drop = pinged_reg[idx_reg] && (elapsed >= {16'b0, loss_ival_reg});
    assign hit_ping = !pinged_reg[idx_reg] && (elapsed >= {16'b0, ping_ival_reg});
    assign hit      = hit_drop || hit_ping;

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        tracked_next     = tracked_reg;
        pinged_next      = pinged_reg;
        last_seq_next    = last_seq_reg;
        ping_ival_next   = ping_ival_reg;
        loss_ival_next   = loss_ival_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        now_next         = now_reg;
        pend_valid_next  = pend_valid_reg;
        pend_action_next = pend_action_reg;
        pend_slot_next   = pend_slot_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_action_next  = out_action_reg;
        out_slot_next    = out_slot_reg;
        out_last_next    = out_last_reg;
        pop              = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = now_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_status.empty && out_free)
                begin
                    pop = 1'b1;
                    out_slot_next = head_cmd.conn;
                    out_last_next = 1'b1;
                    out_action_next = ACT_NONE;
                    out_valid_next = (head_cmd.kind != CMD_TICK);
                    unique case (head_cmd.kind)
                        CMD_ADD:
                        begin
                            tracked_next[head_idx] = 1'b1;
                            pinged_next[head_idx]  = 1'b0;
                            ram_we    = 1'b1;
                            ram_waddr = head_idx;
                            ram_wdata = head_cmd.now;
                        end
                        CMD_DELETE:
                        begin
                            tracked_next[head_idx] = 1'b0;
                            pinged_next[head_idx]  = 1'b0;
                        end
                        CMD_MSG:
                        begin
                            if (head_cmd.counted && (head_cmd.seq <= last_seq_reg))
                            begin
                                out_action_next = ACT_DUP;
                            end
                            else
                            begin
                                out_action_next = ACT_PASS;
                                if (head_cmd.counted)
                                begin
                                    last_seq_next = head_cmd.seq;
                                end
                                if (tracked_reg[head_idx])
                                begin
                                    pinged_next[head_idx] = 1'b0;
                                    ram_we    = 1'b1;
                                    ram_waddr = head_idx;
                                    ram_wdata = head_cmd.now;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            now_next        = head_cmd.now;
                            idx_next        = '0;
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_READ;
                        end
                        default:
                        begin
                            out_action_next = ACT_NONE;
                        end
                    endcase
                end
            end

            // Skip untracked slots, otherwise fetch the slot time
            S_READ:
            begin
                if (tracked_reg[idx_reg])
                begin
                    state_next = S_EVAL;
                end
                else if (last_idx)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Judge the slot; hold if an earlier result cannot leave
            S_EVAL:
            begin
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_action_next = pend_action_reg;
                            out_slot_next   = pend_slot_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_action_next = hit_drop ? ACT_DROP : ACT_PING;
                        pend_slot_next   = CONN_W'(idx_reg);
                        cnt_next         = cnt_reg + 1'b1;
                        if (hit_drop)
                        begin
                            tracked_next[idx_reg] = 1'b0;
                            pinged_next[idx_reg]  = 1'b0;
                        end
                        else
                        begin
                            pinged_next[idx_reg] = 1'b1;
                            ram_we = 1'b1;
                        end
                    end
                    if (last_idx || (hit && (cnt_reg == CNT_W'(MAX_RESULTS - 1))))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end

            // Release the final tick result
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = pend_valid_reg ? pend_action_reg : ACT_NONE;
                    out_slot_next   = pend_valid_reg ? pend_slot_reg : '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes; to be made only while idle, which the block itself does not enforce
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PING_INTERVAL:  ping_ival_next = cfg_wdata[IVAL_W-1:0];
                CFG_LOSS_INTERVAL:  loss_ival_next = cfg_wdata[IVAL_W-1:0];
                CFG_START_SEQUENCE: last_seq_next  = cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tracked_reg    <= '0;
            pinged_reg     <= '0;
            last_seq_reg   <= START_SEQ_RST;
            ping_ival_reg  <= PING_INTERVAL_RST;
            loss_ival_reg  <= LOSS_INTERVAL_RST;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tracked_reg    <= tracked_next;
            pinged_reg     <= pinged_next;
            last_seq_reg   <= last_seq_next;
            ping_ival_reg  <= ping_ival_next;
            loss_ival_reg  <= loss_ival_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        now_reg         <= now_next;
        pend_action_reg <= pend_action_next;
        pend_slot_reg   <= pend_slot_next;
        out_action_reg  <= out_action_next;
        out_slot_reg    <= out_slot_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_slot_reg};
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/connection_keepalive_monitor.sv =====
// ----------------------------------------------------------------------------
// connection_keepalive_monitor
// Timing: an accepted input transaction waits in the command queue until the
// executor pops it and registers its result. Add, delete and message each run
// in the idle state as popped. Tick: each slot passes the read state and a tracked
// one then the evaluate state, after the registered read of the slot time memory,
// then the done state; one result per pinged or dropped slot, or a single empty
// result when none is. Reset: tracked and ping marks clear at once, no clearing
// pass; slot times stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_keepalive_monitor (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [103:0]                      s_axis_tdata, // conn, now_seconds, sequence_req
    input  wire logic [2:0]                        s_axis_tuser, // func
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata, // slot
    output logic [2:0]                             m_axis_tuser, // action
    output logic                                   m_axis_tlast, // last_of_run
    input  wire logic                              cfg_wr_en,
    input  wire logic [ckm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ckm_pkg::SEQ_W-1:0]         cfg_wdata
);
    import ckm_pkg::*;

    cmd_t              push_cmd;
    cmd_t              head_cmd;
    queue_status_t     queue_status;
    logic              push;
    logic              pop;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [TIME_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [TIME_W-1:0] ram_rdata;

    // Classify incoming transactions
    ckm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_status  (queue_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // Decouple front and back
    ckm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (queue_status)
    );

    // Slot last-activity times
    ckm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CONNECTIONS)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Execute commands and drive results
    ckm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .queue_status  (queue_status),
        .pop           (pop),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression bench for the connection keepalive monitor. A queue of commands
// (adds, deletes, ticks, counted and plain messages, spare codes) feeds a
// stream driver. A table model tracks slots, ping marks, activity times and
// the last accepted sequence number. The model works out the actions that
// each accepted transaction must produce, and every returned action is
// checked in order against them. Both stream sides idle at random. The
// intervals and the start sequence are rewritten between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckm_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [SEQ_W-1:0]  SEQ_TOP = {SEQ_W{1'b1}};

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [CONN_W-1:0] conn;
        logic [TIME_W-1:0] now;
        logic [SEQ_W-1:0]  seq;
    } ka_cmd_t;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CONN_W-1:0]   slot;
        logic                last_of_run;
    } ka_action_t;

    // Clock, reset and ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [103:0]         s_axis_tdata = '0;  // conn, now_seconds, sequence_req
    logic [2:0]           s_axis_tuser = '0;  // func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;       // slot
    logic [2:0]           m_axis_tuser;       // action
    logic                 m_axis_tlast;       // last_of_run
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEQ_W-1:0]     cfg_wdata = '0;

    // Table model state and its copy of the registers
    logic                 slot_tracked [CONNECTIONS];
    logic                 slot_pinged  [CONNECTIONS];
    logic [TIME_W-1:0]    slot_time    [CONNECTIONS];
    logic [SEQ_W-1:0]     accepted_seq;
    logic [IVAL_W-1:0]    ping_ival;
    logic [IVAL_W-1:0]    loss_ival;

    ka_cmd_t              pending_cmds [$];
    ka_action_t           due_actions [$];
    ka_cmd_t              drive_cmd;
    ka_cmd_t              taken_cmd;
    ka_action_t           head_action;

    logic                 send_idles = 1'b1;
    logic                 recv_idles = 1'b1;
    int                   errors = 0;
    int                   cycle_count = 0;

    // Stimulus-side tracking of time and sequence
    logic [TIME_W-1:0]    gen_time;
    logic [SEQ_W-1:0]     gen_seq;

    connection_keepalive_monitor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    function automatic logic [SEQ_W-1:0] random_seq();
        return SEQ_W'({$urandom, $urandom});
    endfunction

    // Apply one command to the table and queue the actions it must yield
    task automatic step_table(input ka_cmd_t c);
        logic [ACTION_W-1:0] acts [MAX_RESULTS];
        logic [CONN_W-1:0]   slots [MAX_RESULTS];
        logic [TIME_W-1:0]   idle_for;
        ka_action_t          item;
        int                  found;
        found = 0;
        if (c.func == FUNC_TICK)
        begin
            for (int i = 0; i < CONNECTIONS && found < MAX_RESULTS; i++)
            begin
                if (slot_tracked[i])
                begin
                    idle_for = c.now - slot_time[i];
                    if (slot_pinged[i])
                    begin
                        if (idle_for >= loss_ival)
                        begin
                            slot_tracked[i] = 1'b0;
                            slot_pinged[i] = 1'b0;
                            acts[found] = ACT_DROP;
                            slots[found] = CONN_W'(i);
                            found++;
                        end
                    end
                    else if (idle_for >= ping_ival)
                    begin
                        slot_pinged[i] = 1'b1;
                        slot_time[i] = c.now;
                        acts[found] = ACT_PING;
                        slots[found] = CONN_W'(i);
                        found++;
                    end
                end
            end
            if (found == 0)
            begin
                acts[0] = ACT_NONE;
                slots[0] = '0;
                found = 1;
            end
        end
        else
        begin
            acts[0] = ACT_NONE;
            slots[0] = c.conn;
            found = 1;
            if (c.func == FUNC_ADD)
            begin
                slot_tracked[c.conn] = 1'b1;
                slot_pinged[c.conn] = 1'b0;
                slot_time[c.conn] = c.now;
            end
            else if (c.func == FUNC_DELETE)
            begin
                slot_tracked[c.conn] = 1'b0;
                slot_pinged[c.conn] = 1'b0;
            end
            else if (c.func == FUNC_MSG_COUNT && c.seq <= accepted_seq)
            begin
                acts[0] = ACT_DUP;
            end
            else if (c.func == FUNC_MSG_COUNT || c.func == FUNC_MSG_PLAIN)
            begin
                if (c.func == FUNC_MSG_COUNT)
                    accepted_seq = c.seq;
                if (slot_tracked[c.conn])
                begin
                    slot_pinged[c.conn] = 1'b0;
                    slot_time[c.conn] = c.now;
                end
                acts[0] = ACT_PASS;
            end
        end
        for (int k = 0; k < found; k++)
        begin
            item.action = acts[k];
            item.slot = slots[k];
            item.last_of_run = (k == found - 1);
            due_actions.push_back(item);
        end
    endtask

    // Write one register and mirror it into the model
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SEQ_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_PING_INTERVAL:  ping_ival = value[IVAL_W-1:0];
            CFG_LOSS_INTERVAL:  loss_ival = value[IVAL_W-1:0];
            CFG_START_SEQUENCE:
            begin
                accepted_seq = value;
                gen_seq = value;
            end
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [CONN_W-1:0] conn,
                             input logic [TIME_W-1:0] now, input logic [SEQ_W-1:0] seq);
        ka_cmd_t c;
        c.func = func;
        c.conn = conn;
        c.now = now;
        c.seq = seq;
        pending_cmds.push_back(c);
    endtask

    // Hold until every command is taken and every action returned, then idle
    task automatic settle();
        while (pending_cmds.size() != 0 || s_axis_tvalid || due_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly small time steps, some interval-sized jumps, a few random times
    task automatic queue_random(input int count);
        logic [FUNC_W-1:0] func;
        logic [SEQ_W-1:0]  seq;
        int                pick;
        int                span;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            span = (ping_ival > loss_ival) ? int'(ping_ival) : int'(loss_ival);
            if (pick < 75)
                gen_time = gen_time + $urandom_range(0, 3);
            else if (pick < 95)
                gen_time = gen_time + $urandom_range(0, 2 * span + 2);
            else
                gen_time = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 18)
                func = FUNC_ADD;
            else if (pick < 26)
                func = FUNC_DELETE;
            else if (pick < 46)
                func = FUNC_TICK;
            else if (pick < 70)
                func = FUNC_MSG_COUNT;
            else if (pick < 92)
                func = FUNC_MSG_PLAIN;
            else
                func = FUNC_SPARE_FIRST + FUNC_W'($urandom_range(0, 2));
            seq = random_seq();
            if (func == FUNC_MSG_COUNT)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && gen_seq < SEQ_TOP - 8)
                    seq = gen_seq + SEQ_W'($urandom_range(1, 4));
                else if (pick < 90)
                    seq = (gen_seq < 2) ? gen_seq : gen_seq - SEQ_W'($urandom_range(0, 2));
                if (seq > gen_seq)
                    gen_seq = seq;
            end
            queue_cmd(func, CONN_W'($urandom_range(0, CONNECTIONS - 1)), gen_time, seq);
        end
    endtask

    // Drive the input stream from the pending queue
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (pending_cmds.size() != 0 && !(send_idles && $urandom_range(0, 99) < 17))
            begin
                drive_cmd = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, drive_cmd.seq, drive_cmd.now, drive_cmd.conn};
                s_axis_tuser <= drive_cmd.func;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the output stream at random
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && !(recv_idles && $urandom_range(0, 99) < 17);
    end

    // Run each accepted input transaction through the table model
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            taken_cmd.func = s_axis_tuser;
            taken_cmd.conn = s_axis_tdata[4:0];
            taken_cmd.now = s_axis_tdata[36:5];
            taken_cmd.seq = s_axis_tdata[99:37];
            step_table(taken_cmd);
        end
    end

    // Compare each output transaction with the oldest due action
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_actions.size() == 0)
            begin
                report_mismatch($sformatf("unexpected action %0d slot %0d",
                                          m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                head_action = due_actions.pop_front();
                if (m_axis_tuser !== head_action.action)
                    report_mismatch($sformatf("action %0d, want %0d",
                                              m_axis_tuser, head_action.action));
                if (m_axis_tdata !== {3'b0, head_action.slot})
                    report_mismatch($sformatf("slot %0d, want %0d",
                                              m_axis_tdata, head_action.slot));
                if (m_axis_tlast !== head_action.last_of_run)
                    report_mismatch($sformatf("last flag %b, want %b",
                                              m_axis_tlast, head_action.last_of_run));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CONNECTIONS; i++)
        begin
            slot_tracked[i] = 1'b0;
            slot_pinged[i] = 1'b0;
            slot_time[i] = '0;
        end
        ping_ival = PING_INTERVAL_RST;
        loss_ival = LOSS_INTERVAL_RST;
        accepted_seq = START_SEQ_RST;
        gen_seq = START_SEQ_RST;
        gen_time = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset values
        queue_cmd(FUNC_ADD, 0, 100, 0);
        queue_cmd(FUNC_ADD, 31, 100, SEQ_TOP);
        queue_cmd(FUNC_MSG_COUNT, 0, 105, 0);          // equal to start: duplicate
        queue_cmd(FUNC_MSG_COUNT, 0, 110, 5);
        queue_cmd(FUNC_MSG_COUNT, 31, 110, 5);         // repeat of last: duplicate
        queue_cmd(FUNC_MSG_PLAIN, 31, 115, SEQ_TOP);
        queue_cmd(FUNC_MSG_COUNT, 7, 115, 6);          // untracked slot still passes
        queue_cmd(FUNC_TICK, 9, 139, 0);               // just short of the ping interval
        queue_cmd(FUNC_TICK, 0, 140, 0);               // ping slot 0
        queue_cmd(FUNC_MSG_COUNT, 31, 120, SEQ_TOP);
        queue_cmd(FUNC_MSG_COUNT, 31, 121, SEQ_TOP);
        queue_cmd(FUNC_TICK, 0, 200, 0);               // drop slot 0, ping slot 31
        queue_cmd(FUNC_ADD, 31, 200, 0);               // restart a tracked slot
        queue_cmd(FUNC_DELETE, 31, 201, 0);
        queue_cmd(FUNC_DELETE, 5, 201, 0);
        queue_cmd(FUNC_SPARE_FIRST, 12, 0, random_seq());
        queue_cmd(FUNC_SPARE_FIRST + 3'd1, 19, 32'hFFFF_FFFF, random_seq());
        queue_cmd(FUNC_SPARE_FIRST + 3'd2, 31, 7, random_seq());
        queue_cmd(FUNC_ADD, 3, 32'hFFFF_FFF0, 0);
        queue_cmd(FUNC_TICK, 0, 32'h0000_0010, 0);     // elapsed across the wrap
        queue_cmd(FUNC_TICK, 0, 32'h0000_0011, 0);
        settle();

        // Short intervals, small start sequence
        write_register(CFG_PING_INTERVAL, 5);
        write_register(CFG_LOSS_INTERVAL, 9);
        write_register(CFG_START_SEQUENCE, SEQ_W'($urandom_range(0, 1000)));
        gen_time = $urandom_range(0, 1000);
        queue_random(130);
        settle();

        // Smallest intervals, no idling: fill the table and tick it empty
        write_register(CFG_PING_INTERVAL, 1);
        write_register(CFG_LOSS_INTERVAL, 1);
        write_register(CFG_START_SEQUENCE, 0);
        send_idles = 1'b0;
        recv_idles = 1'b0;
        gen_time = $urandom;
        for (int s = 0; s < CONNECTIONS; s++)
            queue_cmd(FUNC_ADD, CONN_W'(s), gen_time, random_seq());
        queue_cmd(FUNC_TICK, 0, gen_time + 1, 0);
        queue_cmd(FUNC_TICK, 0, gen_time + 2, 0);
        gen_time = gen_time + 2;
        queue_random(110);
        settle();
        send_idles = 1'b1;
        recv_idles = 1'b1;

        // Largest intervals, top start sequence
        write_register(CFG_PING_INTERVAL, 16'hFFFF);
        write_register(CFG_LOSS_INTERVAL, 16'hFFFF);
        write_register(CFG_START_SEQUENCE, SEQ_TOP);
        queue_random(70);
        settle();

        // Random intervals and start, time running over the wrap
        write_register(CFG_PING_INTERVAL, SEQ_W'($urandom_range(2, 40)));
        write_register(CFG_LOSS_INTERVAL, SEQ_W'($urandom_range(2, 80)));
        write_register(CFG_START_SEQUENCE, random_seq() >> $urandom_range(0, 40));
        gen_time = 32'hFFFF_FF00;
        queue_random(130);
        settle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ckm_pkg.sv
sv/ckm_ram.sv
sv/ckm_queue.sv
sv/ckm_front.sv
sv/ckm_back.sv
sv/connection_keepalive_monitor.sv
bench/tb.sv
